/* rtl/core/tcw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and control types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
  localparam int ADDR_W      = $clog2(CELL_COUNT);
  localparam int COL_W       = 7;
  localparam int ROW_W       = 5;
  localparam int CELL_W      = 16;

  // Stream widths
  localparam int IN_W  = 24;
  localparam int OUT_W = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_COL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_ROW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTRIBUTE  = 2'd2;
  localparam logic [7:0]           ATTR_RESET     = 8'h07;

  // Commands
  localparam logic [1:0] CMD_PUT_CURSOR = 2'd0;
  localparam logic [1:0] CMD_PUT_AT     = 2'd1;
  localparam logic [1:0] CMD_SET_CURSOR = 2'd2;
  localparam logic [1:0] CMD_READ       = 2'd3;

  // Characters
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // Controller to datapath
  typedef struct packed {
    logic init_en;      // write one zero cell of the power-up clear
    logic accept;       // input beat taken this cycle
    logic sweep_en;     // write one blank cell of the window clear
    logic result_load;  // move the finished result into the output register
  } tcw_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic init_last;    // last cell of the power-up clear
    logic sweep_need;   // current input would blank a non-empty window
    logic sweep_last;   // last cell of the window clear
    logic out_ok;       // output register free or draining this cycle
  } tcw_stat_t;

  // Cell address: row * SCREEN_COLS + col
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(row) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col);
    return a;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/tcw_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: power-up clear, command accept, window clear and result handoff.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire tcw_pkg::tcw_stat_t stat,
  output tcw_pkg::tcw_ctl_t      ctl
);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_DONE,
    ST_SWEEP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  // Take a beat when idle, or when the pending result leaves this cycle
  always_comb begin
    in_tready = (state_r == ST_IDLE) || ((state_r == ST_DONE) && stat.out_ok);
    accept    = in_tvalid && in_tready;
    ctl.init_en     = (state_r == ST_INIT);
    ctl.accept      = accept;
    ctl.sweep_en    = (state_r == ST_SWEEP);
    ctl.result_load = (state_r == ST_DONE) && stat.out_ok;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (stat.init_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = stat.sweep_need ? ST_SWEEP : ST_DONE;
      end
      ST_DONE: begin
        if (accept) begin
          state_nxt = stat.sweep_need ? ST_SWEEP : ST_DONE;
        end else if (stat.out_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        if (stat.sweep_last) state_nxt = ST_DONE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/tcw_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen store, cursor, configuration, clear sweeps and output register.
// ----------------------------------------------------------------------------
module tcw_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire tcw_pkg::tcw_ctl_t                 ctl,
  output tcw_pkg::tcw_stat_t                     stat,
  input  wire logic [tcw_pkg::IN_W-1:0]          in_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [tcw_pkg::OUT_W-1:0]              out_tdata
);

  localparam int CW = tcw_pkg::COL_W;
  localparam int RW = tcw_pkg::ROW_W;
  localparam int AW = tcw_pkg::ADDR_W;
  localparam logic [CW:0] COLS_X = (CW+1)'(tcw_pkg::SCREEN_COLS);
  localparam logic [RW:0] ROWS_X = (RW+1)'(tcw_pkg::SCREEN_ROWS);
  localparam logic [AW-1:0] LAST_CELL = AW'(tcw_pkg::CELL_COUNT - 1);

  // Screen store
  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];
  logic [tcw_pkg::CELL_W-1:0] rd_data_r;

  // Configuration
  logic [CW-1:0] origin_col_r;
  logic [RW-1:0] origin_row_r;
  logic [7:0]    attr_r;

  // Cursor and sweep counters
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [AW-1:0] init_cnt_r;
  logic [CW-1:0] sw_col_r;
  logic [RW-1:0] sw_row_r;

  // Result of the last accepted beat
  logic          res_clr_r, res_bad_r, res_rd_r;
  logic          res_clr_nxt, res_bad_nxt, res_rd_nxt;
  logic [CW-1:0] res_col_r;
  logic [RW-1:0] res_row_r;
  logic          out_valid_r;
  logic [tcw_pkg::OUT_W-1:0] out_data_r;

  // Input fields
  logic [1:0]    in_cmd;
  logic [7:0]    in_char;
  logic [CW-1:0] in_col;
  logic [RW-1:0] in_row;

  // Decode and put arithmetic
  logic [CW:0]   wlim, hlim_c;
  logic [RW:0]   hlim;
  logic          win_empty;
  logic          in_on, cur_on, is_nl;
  logic [CW:0]   c1, c2;
  logic [RW+1:0] r1, r2;
  logic          put_clear;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [tcw_pkg::CELL_W-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [CW:0]   sw_col_inc;
  logic [RW:0]   sw_row_inc;

  assign in_cmd  = in_tdata[1:0];
  assign in_char = in_tdata[9:2];
  assign in_col  = in_tdata[16:10];
  assign in_row  = in_tdata[21:17];

  // Window limits: a size below the origin counts as zero
  always_comb begin
    wlim   = ({1'b0, origin_col_r} >= COLS_X) ? '0 : COLS_X - {1'b0, origin_col_r};
    hlim   = ({1'b0, origin_row_r} >= ROWS_X) ? '0 : ROWS_X - {1'b0, origin_row_r};
    hlim_c = (CW+1)'(hlim);
    win_empty = ({1'b0, origin_col_r} >= wlim) || ({1'b0, origin_row_r} >= hlim);
  end

  // Put at cursor: newline or advance, then wrap, then clear check
  always_comb begin
    in_on  = ({1'b0, in_col} < COLS_X) && ({1'b0, in_row} < ROWS_X);
    cur_on = ({1'b0, cur_col_r} < COLS_X) && ({1'b0, cur_row_r} < ROWS_X);
    is_nl  = (in_char == tcw_pkg::CHAR_NEWLINE);
    if (is_nl) begin
      c1 = {1'b0, origin_col_r};
      r1 = (RW+2)'(cur_row_r) + 1'b1;
    end else begin
      c1 = {1'b0, cur_col_r} + 1'b1;
      r1 = (RW+2)'(cur_row_r);
    end
    if (c1 >= wlim) begin
      c2 = {1'b0, origin_col_r};
      r2 = r1 + 1'b1;
    end else begin
      c2 = c1;
      r2 = r1;
    end
    put_clear = (r2 >= (RW+2)'(hlim));
  end

  // Command effects on cursor and result flags
  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    res_clr_nxt = 1'b0;
    res_bad_nxt = 1'b0;
    res_rd_nxt  = 1'b0;
    case (in_cmd)
      tcw_pkg::CMD_PUT_CURSOR: begin
        res_bad_nxt = !is_nl && !cur_on;
        if (put_clear) begin
          cur_col_nxt = origin_col_r;
          cur_row_nxt = origin_row_r;
          res_clr_nxt = 1'b1;
        end else begin
          cur_col_nxt = c2[CW-1:0];
          cur_row_nxt = r2[RW-1:0];
        end
      end
      tcw_pkg::CMD_PUT_AT: begin
        res_bad_nxt = !in_on;
      end
      tcw_pkg::CMD_SET_CURSOR: begin
        res_bad_nxt = !in_on;
        if (in_on) begin
          cur_col_nxt = in_col;
          cur_row_nxt = in_row;
        end
      end
      tcw_pkg::CMD_READ: begin
        res_bad_nxt = !in_on;
        res_rd_nxt  = in_on;
      end
      default: res_bad_nxt = 1'b0;
    endcase
  end

  // Sweep position and end tests
  always_comb begin
    sw_col_inc = {1'b0, sw_col_r} + 1'b1;
    sw_row_inc = {1'b0, sw_row_r} + 1'b1;
    stat.init_last  = (init_cnt_r == LAST_CELL);
    stat.sweep_need = (in_cmd == tcw_pkg::CMD_PUT_CURSOR) && put_clear && !win_empty;
    stat.sweep_last = (sw_col_inc == wlim) && ((CW+1)'(sw_row_inc) == hlim_c);
    stat.out_ok     = !out_valid_r || out_tready;
  end

  // Select the single store write of this cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (ctl.init_en) begin
      wr_en   = 1'b1;
      wr_addr = init_cnt_r;
    end else if (ctl.sweep_en) begin
      wr_en   = 1'b1;
      wr_addr = tcw_pkg::cell_addr(sw_row_r, sw_col_r);
      wr_data = {attr_r, tcw_pkg::CHAR_SPACE};
    end else if (ctl.accept) begin
      wr_data = {attr_r, in_char};
      if (in_cmd == tcw_pkg::CMD_PUT_CURSOR) begin
        wr_en   = !is_nl && cur_on;
        wr_addr = tcw_pkg::cell_addr(cur_row_r, cur_col_r);
      end else if (in_cmd == tcw_pkg::CMD_PUT_AT) begin
        wr_en   = in_on;
        wr_addr = tcw_pkg::cell_addr(in_row, in_col);
      end
    end
    rd_addr = in_on ? tcw_pkg::cell_addr(in_row, in_col) : '0;
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (ctl.accept) rd_data_r <= mem[rd_addr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_col_r <= '0;
      origin_row_r <= '0;
      attr_r       <= tcw_pkg::ATTR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tcw_pkg::CFG_ORIGIN_COL: origin_col_r <= cfg_wdata[CW-1:0];
        tcw_pkg::CFG_ORIGIN_ROW: origin_row_r <= cfg_wdata[RW-1:0];
        tcw_pkg::CFG_ATTRIBUTE:  attr_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Cursor, sweep counters and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      init_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.init_en) init_cnt_r <= init_cnt_r + 1'b1;
      if (ctl.accept) begin
        cur_col_r <= cur_col_nxt;
        cur_row_r <= cur_row_nxt;
      end
      if (ctl.result_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sweep walk: columns inside rows, origin to limits
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      sw_col_r <= origin_col_r;
      sw_row_r <= origin_row_r;
    end else if (ctl.sweep_en) begin
      if (sw_col_inc == wlim) begin
        sw_col_r <= origin_col_r;
        sw_row_r <= sw_row_inc[RW-1:0];
      end else begin
        sw_col_r <= sw_col_inc[CW-1:0];
      end
    end
  end

  // Result and output payload registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      res_col_r <= cur_col_nxt;
      res_row_r <= cur_row_nxt;
      res_clr_r <= res_clr_nxt;
      res_bad_r <= res_bad_nxt;
      res_rd_r  <= res_rd_nxt;
    end
    if (ctl.result_load) begin
      out_data_r <= {2'b00, res_bad_r, res_clr_r, res_row_r, res_col_r,
                     (res_rd_r ? rd_data_r : {tcw_pkg::CELL_W{1'b0}})};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

/* rtl/core/text_console_writer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer
// 80x25 text screen store with cursor, print window and cell access.
// ----------------------------------------------------------------------------
// Commands arrive as beats on the in_ channel; every command returns exactly
// one result beat on the out_ channel (read data, cursor after the command,
// window-cleared and bad-position flags). origin_col, origin_row and the
// attribute byte are set through the cfg_ write port; the user must write them
// only while the block is idle, which is not enforced. Results pass through
// the result register into the output register. While the output drains and no
// window clear runs, one command is taken per cycle. A put at the cursor that
// reaches the bottom of the print window blanks the window (up to 2000 cells)
// one cell per cycle through the single write port of the screen store. After
// reset the store is cleared one cell per cycle; in_tready stays low until the
// last cell is written. Configuration writes are taken during that time. When
// the receiver stalls, one finished result waits in the output register and
// one more in the result register; after that in_tready drops.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [1:0] cmd, [9:2] char_code, [16:10] column, [21:17] row, [23:22] zero
  input  wire logic [tcw_pkg::IN_W-1:0]       in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [15:0] read_data, [22:16] cursor_col_now, [27:23] cursor_row_now,
  // [28] window_cleared, [29] bad_position, [31:30] zero
  output logic [tcw_pkg::OUT_W-1:0]           out_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  tcw_pkg::tcw_ctl_t  ctl;
  tcw_pkg::tcw_stat_t stat;

  // Sequencer
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Store, cursor and output register
  tcw_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
